// File: rtl/gconv_pkg.sv
// Shared types and fixed field widths for the grayscale 2D convolution block.
// No dependencies.
package gconv_pkg;

   localparam int ROW_W    = 12;
   localparam int COL_W    = 10;
   localparam int PIX_W    = 8;
   localparam int CIDX_W   = 6;
   localparam int CVAL_W   = 16;
   localparam int HGT_W    = 13;
   localparam int CWID_W   = 11;
   localparam int KSZ_W    = 3;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KSIZE  = 2'd2;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_COEF  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_COPY,
      ST_MAC,
      ST_DRAIN,
      ST_EMIT
   } state_type;

endpackage

// File: rtl/grayscale_2d_convolution.sv
// Grayscale KxK convolution on a raster pixel stream, line store and kernel in memories.
// Depends on gconv_pkg.
// One item at a time. A coefficient word or a pixel with no result leaves the block idle.
// Each result runs start, copy, drain and emit for a border copy (start, drain and emit
// with an empty kernel), or start, MAC, drain and emit (one window tap read per cycle
// from the line memory, then multiply and accumulate stages), plus output stalls.
// Synchronous active-high reset clears counters, kernel valid bits and config
// (width 1024, height 1024, kernel 3); the line memory is not cleared.
module grayscale_2d_convolution #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_KERNEL = 7,
   parameter int COEF_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pixel[7:0], coef_index[13:8], coef_value[29:14], zero pad
   input  logic [gconv_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_type
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_row[11:0], out_col[21:12], out_pixel[29:22], zero pad
   output logic [gconv_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast,
   // frame_last
   output logic                                rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gconv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gconv_pkg::CSR_DATA_W-1:0]    csr_data
);
   import gconv_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int SW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int NCOEF = MAX_KERNEL * MAX_KERNEL;
   localparam int CIW   = (NCOEF > 1) ? $clog2(NCOEF) : 1;
   localparam int DEPTH = MAX_KERNEL * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int PRW   = PIX_W + 1 + COEF_BITS;
   localparam int ACW   = PRW + 7;

   logic [PIX_W-1:0]     line_mem [DEPTH];
   logic [COEF_BITS-1:0] coef_mem [NCOEF];

   state_type state_ff, state_in;

   logic [WW-1:0]    wid_ff, wid_in;
   logic [HGT_W-1:0] hgt_ff, hgt_in;
   logic [KSZ_W-1:0] ksz_ff, ksz_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [SW-1:0]    slot_ff, slot_in;
   logic [NCOEF-1:0] cvld_ff, cvld_in;

   logic [ROW_W-1:0] ir_ff, ir_in;
   logic [SW-1:0]    islot_ff, islot_in;
   logic [ROW_W-1:0] y_ff, y_in, yhi_ff, yhi_in;
   logic [CW-1:0]    x_ff, x_in, xlo_ff, xlo_in, xhi_ff, xhi_in;
   logic             intr_ff, intr_in;
   logic [KSZ_W-1:0] v_ff, v_in, u_ff, u_in;
   logic [CIW-1:0]   ci_ff, ci_in;

   logic             rdv_ff, rdv_in, mulv_ff, mulv_in;
   logic signed [PRW-1:0] prod_ff, prod_in;
   logic signed [ACW-1:0] acc_ff, acc_in;
   logic [PIX_W-1:0]     line_q_ff;
   logic [COEF_BITS-1:0] coef_q_ff;
   logic                 coef_qv_ff;

   logic             rsp_v_ff, rsp_v_in;
   logic [RSP_DATA_W-1:0] rsp_d_ff, rsp_d_in;
   logic             rsp_l_ff, rsp_l_in, rsp_f_ff, rsp_f_in;

   logic [1:0]       half;
   logic             req_fire, pix_fire, coef_fire, csr_fire;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic [CIW-1:0]   cw_addr;
   logic             mac_issue, mac_done, emit_go, is_intr;
   logic [2:0]       dy;
   logic [3:0]       delta;
   logic [SW+1:0]    stmp;
   logic [SW-1:0]    rslot;
   logic [CW:0]      rcol;
   logic [ROW_W-1:0] ylo_c;
   logic             has_y, has_x;
   logic [CW-1:0]    xlo_c, xhi_c;
   logic [ROW_W-1:0] yhi_c;
   logic signed [COEF_BITS-1:0] coef_eff;
   logic [PIX_W-1:0] clamped;
   logic [12:0]      wv;

   assign half      = 2'(ksz_ff >> 1);
   assign req_fire  = req_tvalid && req_tready;
   assign pix_fire  = req_fire && (req_tuser == REQ_PIXEL);
   assign coef_fire = req_fire && (req_tuser == REQ_COEF);
   assign csr_fire  = csr_valid && csr_ready;
   assign emit_go   = !rsp_v_ff || rsp_tready;
   assign mac_done  = (u_ff == ksz_ff - 3'd1) && (v_ff == ksz_ff - 3'd1);

   // window/copy read address
   assign dy    = 3'(ir_ff - y_ff);
   assign delta = (state_ff == ST_MAC) ? 4'({1'b0, dy} + 4'(half) - 4'(v_ff)) : 4'(dy);
   always_comb begin
      stmp = (SW+2)'(islot_ff) + (SW+2)'(MAX_KERNEL) - (SW+2)'(delta);
      if (stmp >= (SW+2)'(MAX_KERNEL)) stmp = stmp - (SW+2)'(MAX_KERNEL);
      rslot = SW'(stmp);
   end
   assign rcol    = (state_ff == ST_MAC) ? ((CW+1)'(x_ff) + (CW+1)'(u_ff) - (CW+1)'(half))
                                         : (CW+1)'(x_ff);
   assign rd_addr = AW'(AW'(rslot) * AW'(MAX_WIDTH) + AW'(rcol[CW-1:0]));
   assign wr_addr = AW'(AW'(slot_ff) * AW'(MAX_WIDTH) + AW'(col_ff));
   assign cw_addr = CIW'(req_tdata[13:8]);

   assign is_intr = ((CW+1)'(x_ff) >= (CW+1)'(half))
      && ((WW+1)'(x_ff) + (WW+1)'(half) < (WW+1)'(wid_ff))
      && (y_ff >= ROW_W'(half))
      && ((HGT_W+1)'(y_ff) + (HGT_W+1)'(half) < (HGT_W+1)'(hgt_ff));

   // result ranges of an incoming pixel
   always_comb begin
      ylo_c = (row_ff >= ROW_W'(half)) ? row_ff - ROW_W'(half) : '0;
      has_y = (HGT_W'(row_ff) == hgt_ff - 13'd1) || (row_ff >= ROW_W'(half));
      yhi_c = (HGT_W'(row_ff) == hgt_ff - 13'd1) ? row_ff : ylo_c;
      xlo_c = (col_ff >= CW'(half)) ? col_ff - CW'(half) : '0;
      has_x = (WW'(col_ff) == wid_ff - WW'(1)) || (col_ff >= CW'(half));
      xhi_c = (WW'(col_ff) == wid_ff - WW'(1)) ? col_ff : xlo_c;
   end

   assign coef_eff = coef_qv_ff ? signed'(coef_q_ff) : '0;
   assign clamped  = (acc_ff < 0) ? '0
                   : (acc_ff > ACW'(255)) ? 8'd255 : acc_ff[PIX_W-1:0];

   always_ff @(posedge clock) begin
      if (pix_fire) line_mem[wr_addr] <= req_tdata[PIX_W-1:0];
      line_q_ff <= line_mem[rd_addr];
      if (coef_fire && (req_tdata[13:8] < 6'(NCOEF)))
         coef_mem[cw_addr] <= req_tdata[14 +: COEF_BITS];
      coef_q_ff <= coef_mem[ci_ff];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (pix_fire && has_y && has_x) state_in = ST_START;
         ST_START: state_in = is_intr ? ((ksz_ff == '0) ? ST_DRAIN : ST_MAC) : ST_COPY;
         ST_COPY:  state_in = ST_DRAIN;
         ST_MAC:   if (mac_done) state_in = ST_DRAIN;
         ST_DRAIN: if (!rdv_ff && !mulv_ff) state_in = ST_EMIT;
         ST_EMIT:  if (emit_go)
                      state_in = (x_ff == xhi_ff && y_ff == yhi_ff) ? ST_IDLE : ST_START;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      wid_in = wid_ff; hgt_in = hgt_ff; ksz_in = ksz_ff;
      row_in = row_ff; col_in = col_ff; slot_in = slot_ff; cvld_in = cvld_ff;
      ir_in = ir_ff; islot_in = islot_ff; y_in = y_ff; yhi_in = yhi_ff;
      x_in = x_ff; xlo_in = xlo_ff; xhi_in = xhi_ff; intr_in = intr_ff;
      v_in = v_ff; u_in = u_ff; ci_in = ci_ff;
      acc_in = acc_ff;
      rsp_v_in = rsp_v_ff && !rsp_tready;
      rsp_d_in = rsp_d_ff; rsp_l_in = rsp_l_ff; rsp_f_in = rsp_f_ff;
      mac_issue = 1'b0;
      req_tready = 1'b0;
      csr_ready  = 1'b0;
      wv = 13'(csr_data[CWID_W-1:0]);
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            csr_ready  = !req_tvalid;
            if (coef_fire && (req_tdata[13:8] < 6'(NCOEF))) cvld_in[cw_addr] = 1'b1;
            if (pix_fire) begin
               ir_in = row_ff; islot_in = slot_ff;
               y_in = ylo_c; yhi_in = yhi_c;
               x_in = xlo_c; xlo_in = xlo_c; xhi_in = xhi_c;
               if (WW'(col_ff) + WW'(1) >= wid_ff) begin
                  col_in = '0;
                  if (HGT_W'(row_ff) + 13'd1 >= hgt_ff) begin
                     row_in = '0; slot_in = '0;
                  end else begin
                     row_in  = row_ff + 12'd1;
                     slot_in = (slot_ff == SW'(MAX_KERNEL - 1)) ? '0 : slot_ff + SW'(1);
                  end
               end else begin
                  col_in = col_ff + CW'(1);
               end
            end
            if (csr_fire) begin
               case (csr_index)
                  CSR_WIDTH: begin
                     if (wv == '0) wid_in = WW'(1);
                     else if (wv > 13'(MAX_WIDTH)) wid_in = WW'(MAX_WIDTH);
                     else wid_in = WW'(wv);
                  end
                  CSR_HEIGHT: begin
                     if (csr_data == '0) hgt_in = 13'd1;
                     else if (csr_data > 13'(HEIGHT_LIMIT)) hgt_in = 13'(HEIGHT_LIMIT);
                     else hgt_in = csr_data;
                  end
                  CSR_KSIZE: begin
                     if (csr_data[KSZ_W-1:0] > KSZ_W'(MAX_KERNEL)) ksz_in = KSZ_W'(MAX_KERNEL);
                     else ksz_in = csr_data[KSZ_W-1:0];
                  end
                  default: ;
               endcase
               if (csr_index == CSR_WIDTH || csr_index == CSR_HEIGHT
                   || csr_index == CSR_KSIZE) begin
                  row_in = '0; col_in = '0; slot_in = '0;
               end
            end
         end
         ST_START: begin
            intr_in = is_intr;
            acc_in = '0; v_in = '0; u_in = '0; ci_in = '0;
         end
         ST_MAC: begin
            mac_issue = 1'b1;
            ci_in = ci_ff + CIW'(1);
            if (u_ff == ksz_ff - 3'd1) begin
               u_in = '0; v_in = v_ff + 3'd1;
            end else begin
               u_in = u_ff + 3'd1;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_v_in = 1'b1;
               rsp_d_in = {(RSP_DATA_W-30)'(0), intr_ff ? clamped : line_q_ff,
                           COL_W'(x_ff), y_ff};
               rsp_l_in = (x_ff == xhi_ff) && (y_ff == yhi_ff);
               rsp_f_in = (HGT_W'(y_ff) == hgt_ff - 13'd1) && (WW'(x_ff) == wid_ff - WW'(1));
               if (x_ff == xhi_ff) begin
                  x_in = xlo_ff; y_in = y_ff + 12'd1;
               end else begin
                  x_in = x_ff + CW'(1);
               end
            end
         end
         default: ;
      endcase
      if (mulv_ff) acc_in = acc_ff + ACW'(prod_ff);
      rdv_in  = mac_issue;
      mulv_in = rdv_ff;
      prod_in = signed'({1'b0, line_q_ff}) * coef_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wid_ff   <= WW'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
         hgt_ff   <= 13'd1024;
         ksz_ff   <= KSZ_W'(MAX_KERNEL < 3 ? MAX_KERNEL : 3);
         row_ff   <= '0;
         col_ff   <= '0;
         slot_ff  <= '0;
         cvld_ff  <= '0;
         rdv_ff   <= 1'b0;
         mulv_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wid_ff   <= wid_in;
         hgt_ff   <= hgt_in;
         ksz_ff   <= ksz_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         slot_ff  <= slot_in;
         cvld_ff  <= cvld_in;
         rdv_ff   <= rdv_in;
         mulv_ff  <= mulv_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      ir_ff <= ir_in; islot_ff <= islot_in;
      y_ff <= y_in; yhi_ff <= yhi_in;
      x_ff <= x_in; xlo_ff <= xlo_in; xhi_ff <= xhi_in;
      intr_ff <= intr_in;
      v_ff <= v_in; u_ff <= u_in; ci_ff <= ci_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      coef_qv_ff <= cvld_ff[ci_ff];
      rsp_d_ff <= rsp_d_in; rsp_l_ff <= rsp_l_in; rsp_f_ff <= rsp_f_in;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;
   assign rsp_tlast  = rsp_l_ff;
   assign rsp_tuser  = rsp_f_ff;

endmodule

// File: tb/tb_grayscale_2d_convolution.sv
// Self-checking testbench for grayscale_2d_convolution: drives pixel and kernel words,
// predicts every output pixel from its own line store and kernel copy, checks in order.
// Depends on gconv_pkg and the grayscale_2d_convolution RTL.
module tb_grayscale_2d_convolution;
   timeunit 1ns;
   timeprecision 1ps;
   import gconv_pkg::*;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [PIX_W-1:0] pix;
      logic             run_last;
      logic             frame_last;
   } out_pixel_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid, req_tready, req_tuser;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid, rsp_tready, rsp_tlast, rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   grayscale_2d_convolution i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor state
   logic [PIX_W-1:0]         line_mem [0:7*1024-1];
   logic signed [CVAL_W-1:0] kernel_mem [0:48];
   int unsigned              cur_row, cur_col;
   logic [CWID_W-1:0]        width_reg;
   logic [HGT_W-1:0]         height_reg;
   logic [KSZ_W-1:0]         ksize_reg;

   out_pixel_type pending_pixels[$];
   int         error_count;
   int         items_sent;
   int         send_idle, recv_idle;
   int         hold_left;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > 1024) return 1024;
      return width_reg;
   endfunction

   function automatic int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
      return height_reg;
   endfunction

   function automatic logic [PIX_W-1:0] line_at(int unsigned y, int unsigned x);
      return line_mem[(y % 7) * 1024 + (x % 1024)];
   endfunction

   function automatic logic [PIX_W-1:0] window_value(int unsigned y, int unsigned x,
         int unsigned w, int unsigned hg, int unsigned k, int unsigned half);
      longint acc;
      acc = 0;
      if (!(y >= half && y + half < hg && x >= half && x + half < w))
         return line_at(y, x);
      for (int v = 0; v < k; v++)
         for (int u = 0; u < k; u++)
            acc += longint'(line_at(y - half + v, x - half + u)) *
                   longint'(kernel_mem[v * k + u]);
      if (acc > 255) acc = 255;
      if (acc < 0) acc = 0;
      return acc[PIX_W-1:0];
   endfunction

   function automatic void predict_pixel(logic [PIX_W-1:0] p);
      int unsigned w, hg, k, half, ylo, yhi, xlo, xhi;
      out_pixel_type o;
      w = eff_width();
      hg = eff_height();
      k = ksize_reg;
      half = k / 2;
      line_mem[(cur_row % 7) * 1024 + (cur_col % 1024)] = p;
      if (cur_row == hg - 1) begin
         ylo = (cur_row >= half) ? cur_row - half : 0;
         yhi = hg - 1;
      end else if (cur_row >= half) begin
         ylo = cur_row - half;
         yhi = ylo;
      end else begin
         ylo = 1;
         yhi = 0;
      end
      if (cur_col == w - 1) begin
         xlo = (cur_col >= half) ? cur_col - half : 0;
         xhi = w - 1;
      end else if (cur_col >= half) begin
         xlo = cur_col - half;
         xhi = xlo;
      end else begin
         xlo = 1;
         xhi = 0;
      end
      if (ylo <= yhi && xlo <= xhi) begin
         for (int unsigned y = ylo; y <= yhi; y++) begin
            for (int unsigned x = xlo; x <= xhi; x++) begin
               o.row = y[ROW_W-1:0];
               o.col = x[COL_W-1:0];
               o.pix = window_value(y, x, w, hg, k, half);
               o.run_last = (y == yhi && x == xhi);
               o.frame_last = (y == hg - 1 && x == w - 1);
               pending_pixels.push_back(o);
            end
         end
      end
      cur_col++;
      if (cur_col >= w) begin
         cur_col = 0;
         cur_row++;
         if (cur_row >= hg) cur_row = 0;
      end
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      error_count++;
      if (error_count <= 30)
         $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
   endtask

   // one word on the request side; prediction at the accepting edge
   task automatic send_word(logic kind, logic [PIX_W-1:0] p, logic [CIDX_W-1:0] idx,
                            logic [CVAL_W-1:0] val);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, val, idx, p};
      do @(posedge clock); while (!req_tready);
      if (kind == REQ_COEF) begin
         if (idx < 49) kernel_mem[idx] = val;
      end else begin
         predict_pixel(p);
      end
      items_sent++;
   endtask

   task automatic send_pixel(logic [PIX_W-1:0] p);
      send_word(REQ_PIXEL, p, CIDX_W'($urandom), CVAL_W'($urandom));
   endtask

   task automatic send_coef(logic [CIDX_W-1:0] idx, logic [CVAL_W-1:0] val);
      send_word(REQ_COEF, PIX_W'($urandom), idx, val);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_WIDTH:  width_reg  = val[CWID_W-1:0];
         CSR_HEIGHT: height_reg = val[HGT_W-1:0];
         CSR_KSIZE:  ksize_reg  = val[KSZ_W-1:0];
         default: ;
      endcase
      cur_row = 0;
      cur_col = 0;
   endtask

   task automatic set_frame(int w, int h, int k);
      write_reg(CSR_WIDTH, CSR_DATA_W'(w));
      write_reg(CSR_HEIGHT, CSR_DATA_W'(h));
      write_reg(CSR_KSIZE, CSR_DATA_W'(k));
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      out_pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected word, row", rsp_tdata[11:0], -1);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_tdata[11:0] != want.row) report_mismatch("row", rsp_tdata[11:0], want.row);
            if (rsp_tdata[21:12] != want.col)
               report_mismatch("col", rsp_tdata[21:12], want.col);
            if (rsp_tdata[29:22] != want.pix)
               report_mismatch("pixel", rsp_tdata[29:22], want.pix);
            if (rsp_tlast != want.run_last) report_mismatch("tlast", rsp_tlast, want.run_last);
            if (rsp_tuser != want.frame_last)
               report_mismatch("frame_last", rsp_tuser, want.frame_last);
         end
      end
   end

   task automatic test_directed();
      // identity center tap, extremes elsewhere, out-of-range indexes ignored
      set_frame(4, 4, 3);
      send_coef(6'd4, 16'sd1);
      send_coef(6'd0, 16'h8000);
      send_coef(6'd48, 16'h7FFF);
      send_coef(6'd49, 16'd5);
      send_coef(6'd63, 16'hFFFF);
      for (int i = 0; i < 16; i++)
         send_pixel((i % 3 == 0) ? 8'd255 : (i % 3 == 1) ? 8'd0 : 8'(i * 17));
      // empty kernel, zero sizes clamp to 1x1
      set_frame(0, 0, 0);
      send_pixel(8'd200);
      send_pixel(8'd7);
      // single tap kernel, scaling and clamping
      send_coef(6'd0, 16'sd2);
      set_frame(3, 1, 1);
      send_pixel(8'd100);
      send_pixel(8'd255);
      send_pixel(8'd1);
      // oversize registers clamp to the maximum frame
      set_frame(13'h1FFF, 13'h1FFF, 7);
      repeat (4) send_pixel(8'($urandom));
   endtask

   task automatic test_random(int target);
      int w, h, k, n, stop;
      target = items_sent + target;
      while (items_sent < target) begin
         w = $urandom_range(1, 10);
         h = $urandom_range(1, 8);
         k = $urandom_range(0, 7);
         set_frame(w, h, k);
         for (int i = 0; i < k * k; i++)
            send_coef(CIDX_W'(i), ($urandom_range(0, 9) == 0) ? CVAL_W'($urandom)
                                  : CVAL_W'($urandom_range(0, 8) - 4));
         n = w * h;
         stop = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n) : n;
         for (int i = 0; i < stop; i++) begin
            if ($urandom_range(0, 19) == 0)
               send_coef(CIDX_W'($urandom_range(0, 63)), CVAL_W'($urandom_range(0, 4) - 2));
            send_pixel(8'($urandom));
         end
      end
   endtask

   task automatic test_backpressure();
      set_frame(6, 4, 3);
      @(posedge clock);
      hold_left = 300;
      for (int i = 0; i < 24; i++) send_pixel(8'($urandom));
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      error_count = 0;
      items_sent = 0;
      hold_left = 0;
      send_idle = 26;
      recv_idle = 70;
      for (int i = 0; i < 49; i++) kernel_mem[i] = '0;
      for (int i = 0; i < 7 * 1024; i++) line_mem[i] = '0;
      width_reg = 11'd1024;
      height_reg = 13'd1024;
      ksize_reg = 3'd3;
      cur_row = 0;
      cur_col = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(60);
      send_idle = 70;
      recv_idle = 26;
      test_random(60);
      test_backpressure();
      send_idle = 0;
      recv_idle = 0;
      test_random(60);

      wait_idle();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
